// ----- hw/rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DataW   = 32;
	localparam int KindW   = 2;
	localparam int StatusW = 2;
	localparam int OccW    = 4;

	// operation codes
	localparam logic [KindW-1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [KindW-1:0] KIND_PUSH_REAR  = 2'd1;
	localparam logic [KindW-1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [KindW-1:0] KIND_POP_REAR   = 2'd3;

	// status codes
	localparam logic [StatusW-1:0] ST_OK        = 2'd0;
	localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_POP_WAIT,
		S_FRONT_RD,
		S_FRONT_WAIT
	} cdq_state_t;

endpackage

// ----- hw/rtl/cdq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/circular_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed 32-bit entries in a circular RAM.
// ----------------------------------------------------------------------------
// Busy states: S_OP, then S_POP_WAIT for a successful pop or S_FRONT_RD
//   otherwise, then S_FRONT_WAIT; the result is on the outputs in the cycle
//   after the last busy cycle. One transaction runs at a time, as the
//   single RAM read port serves the popped entry, then the new front entry.
// A new start is taken in the same cycle that done is shown; the receiver
//   cannot stall, so results never back up.
// Reset: arst_n clears indices, count and the sequencer; RAM is not cleared
//   (only entries between front and rear are ever read).
// ----------------------------------------------------------------------------
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [KindW-1:0]          kind,
	input  logic signed [DataW-1:0]   data_in,
	output logic                      done,
	output logic [StatusW-1:0]        status,
	output logic signed [DataW-1:0]   popped_value,
	output logic signed [DataW-1:0]   front_value,
	output logic                      is_empty,
	output logic [OccW-1:0]           occupancy
);

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	// sequencer
	cdq_state_t state_q, state_d;

	// deque bookkeeping
	logic [IdxW-1:0] front_q, rear_q;
	logic [CntW-1:0] count_q;

	// latched transaction
	logic [KindW-1:0] kind_q;
	logic [DataW-1:0] data_q;

	// RAM port
	logic             ram_we;
	logic [IdxW-1:0]  ram_waddr, ram_raddr;
	logic [DataW-1:0] ram_wdata, ram_rdata;

	// result registers
	logic               done_q;
	logic [StatusW-1:0] status_q;
	logic [DataW-1:0]   popped_q, front_val_q;

	// decode of the latched op against current occupancy
	logic is_push, is_full, is_empty_now, push_ok, pop_ok;
	logic [IdxW-1:0] front_dn, rear_up, front_up, rear_dn;

	assign is_push      = (kind_q == KIND_PUSH_FRONT) || (kind_q == KIND_PUSH_REAR);
	assign is_full      = (count_q == CntFull);
	assign is_empty_now = (count_q == '0);
	assign push_ok      = is_push && !is_full;
	assign pop_ok       = !is_push && !is_empty_now;

	// wrapping neighbors; DEPTH need not be a power of two
	assign front_dn = (front_q == '0) ? IdxLast : front_q - 1'b1;
	assign front_up = (front_q == IdxLast) ? '0 : front_q + 1'b1;
	assign rear_up  = (rear_q == IdxLast) ? '0 : rear_q + 1'b1;
	assign rear_dn  = (rear_q == '0) ? IdxLast : rear_q - 1'b1;

	cdq_ram #(
		.WIDTH (DataW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_OP;
				end
			end
			S_OP: begin
				// successful pops read the victim entry first; everything else goes
				// straight to the front read
				state_d = pop_ok ? S_POP_WAIT : S_FRONT_RD;
			end
			S_POP_WAIT:   state_d = S_FRONT_WAIT;
			S_FRONT_RD:   state_d = S_FRONT_WAIT;
			S_FRONT_WAIT: state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// RAM controls per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = data_q;
		ram_raddr = front_q;
		case (state_q)
			S_OP: begin
				if (push_ok) begin
					ram_we = 1'b1;
					if (is_empty_now) begin
						ram_waddr = '0;
					end else if (kind_q == KIND_PUSH_FRONT) begin
						ram_waddr = front_dn;
					end else begin
						ram_waddr = rear_up;
					end
				end
				// pop address: the entry being removed
				ram_raddr = (kind_q == KIND_POP_REAR) ? rear_q : front_q;
			end
			// front_q already holds the post-op index here; the write in
			// S_OP has landed, so the read sees the new entry
			S_POP_WAIT: ram_raddr = front_q;
			S_FRONT_RD: ram_raddr = front_q;
			default:    ram_raddr = front_q;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FRONT_WAIT);
			if (state_q == S_OP) begin
				if (push_ok) begin
					count_q <= count_q + 1'b1;
					if (is_empty_now) begin
						front_q <= '0;
						rear_q  <= '0;
					end else if (kind_q == KIND_PUSH_FRONT) begin
						front_q <= front_dn;
					end else begin
						rear_q <= rear_up;
					end
				end else if (pop_ok) begin
					count_q <= count_q - 1'b1;
					// last entry out: indices stay, next push resets them
					if (count_q != CntW'(1)) begin
						if (kind_q == KIND_POP_FRONT) begin
							front_q <= front_up;
						end else begin
							rear_q <= rear_dn;
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q <= kind;
			data_q <= data_in;
		end
		if (state_q == S_OP) begin
			popped_q <= '0;
			if (is_push) begin
				status_q <= is_full ? ST_OVERFLOW : ST_OK;
			end else begin
				status_q <= is_empty_now ? ST_UNDERFLOW : ST_OK;
			end
		end
		if (state_q == S_POP_WAIT) begin
			popped_q <= ram_rdata;
		end
		if (state_q == S_FRONT_WAIT) begin
			front_val_q <= (count_q != '0) ? ram_rdata : '0;
		end
	end

	// front_val_q lands with done; status/popped/count are stable by then
	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = front_val_q;
	assign is_empty     = (count_q == '0);
	assign occupancy    = OccW'(count_q);

endmodule

// ----- hw/rtl/cdq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
	import cdq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [StatusW-1:0]      status,
	input logic signed [DataW-1:0] popped_value,
	input logic signed [DataW-1:0] front_value,
	input logic                    is_empty,
	input logic [OccW-1:0]         occupancy
);

	// transaction taken: the block must go busy and not flag a result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not start");

	// result only shows while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// empty result carries no occupancy and a zero front
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (occupancy == '0 && front_value == '0))
		else $error("empty result with stale fields");

	// underflow only from empty, nothing popped
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDERFLOW) |-> (is_empty && popped_value == '0))
		else $error("bad underflow result");

	// an overflowed push pops nothing and leaves the deque non-empty
	a_push_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVERFLOW) |-> (popped_value == '0 && !is_empty))
		else $error("bad overflow result");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
